>>> hdl/upn_pkg.sv
// ----------------------------------------------------------------------------
// upn_pkg
// Shared types, codes and character helpers for the URI percent normalizer.
// ----------------------------------------------------------------------------
package upn_pkg;

    // Input beat: one byte of the URI string
    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in;

    // Output beat: one normalized byte and its status
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic [1:0] out_status;
    } t_out;

    // Result set made by one input byte: zero, one or three beats
    localparam int unsigned MaxRes = 3;

    typedef struct packed {
        logic [1:0]            cnt;
        t_out [MaxRes-1:0]     res;
    } t_res_set;

    // Escape tracking state
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_PCT  = 2'd1,
        PH_HI   = 2'd2,
        PH_DROP = 2'd3
    } t_phase;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_HEX = 2'd1;
    localparam logic [1:0] ST_NUL     = 2'd2;

    // Characters
    localparam logic [7:0] CH_PCT   = 8'h25;  // '%'
    localparam logic [7:0] CH_0     = 8'h30;  // '0'
    localparam logic [7:0] CH_9     = 8'h39;  // '9'
    localparam logic [7:0] CH_UA    = 8'h41;  // 'A'
    localparam logic [7:0] CH_UF    = 8'h46;  // 'F'
    localparam logic [7:0] CH_UZ    = 8'h5A;  // 'Z'
    localparam logic [7:0] CH_LA    = 8'h61;  // 'a'
    localparam logic [7:0] CH_LF    = 8'h66;  // 'f'
    localparam logic [7:0] CH_LZ    = 8'h7A;  // 'z'
    localparam logic [7:0] CH_DASH  = 8'h2D;  // '-'
    localparam logic [7:0] CH_DOT   = 8'h2E;  // '.'
    localparam logic [7:0] CH_USCR  = 8'h5F;  // '_'
    localparam logic [7:0] CH_TILDE = 8'h7E;  // '~'
    localparam logic [3:0] HEX_TEN  = 4'hA;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic is_upper_hex(input logic [7:0] c);
        return (c >= CH_UA) && (c <= CH_UF);
    endfunction

    function automatic logic is_lower_hex(input logic [7:0] c);
        return (c >= CH_LA) && (c <= CH_LF);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_digit(c) || is_upper_hex(c) || is_lower_hex(c);
    endfunction

    // Nibble value of a hex digit; zero for anything else
    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (is_digit(c)) begin
            d = c - CH_0;
        end else if (is_upper_hex(c)) begin
            d = c - CH_UA + {4'd0, HEX_TEN};
        end else if (is_lower_hex(c)) begin
            d = c - CH_LA + {4'd0, HEX_TEN};
        end
        return d[3:0];
    endfunction

    // Upper-case hex digit for a nibble
    function automatic logic [7:0] hex_char(input logic [3:0] v);
        logic [7:0] c;
        if (v < HEX_TEN) begin
            c = CH_0 + {4'd0, v};
        end else begin
            c = CH_UA + {4'd0, v - HEX_TEN};
        end
        return c;
    endfunction

    // RFC 3986 unreserved set
    function automatic logic unreserved(input logic [7:0] v);
        return ((v >= CH_UA) && (v <= CH_UZ)) || ((v >= CH_LA) && (v <= CH_LZ)) ||
               is_digit(v) || (v == CH_DASH) || (v == CH_DOT) ||
               (v == CH_USCR) || (v == CH_TILDE);
    endfunction

endpackage

>>> hdl/upn_decode.sv
// ----------------------------------------------------------------------------
// upn_decode
// Escape tracker: holds the escape phase and first nibble, and turns one
// registered input byte into its result set in a single combinational pass.
// ----------------------------------------------------------------------------
module upn_decode (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  upn_pkg::t_in    i_item,
    output upn_pkg::t_res_set o_set
);
    import upn_pkg::*;

    t_phase     r_phase, n_phase;
    logic [3:0] r_hi, n_hi;
    logic [7:0] oct;
    t_res_set   set;

    assign oct = {r_hi, hex_val(i_item.in_byte)};

    // Next state and result set
    always_comb begin
        n_phase = r_phase;
        n_hi    = r_hi;
        set     = '0;
        case (r_phase)
            PH_IDLE: begin
                if (i_item.in_byte == CH_PCT) begin
                    if (i_item.in_last) begin
                        set.cnt    = 2'd1;
                        set.res[0] = '{out_byte: 8'd0, out_last: 1'b1,
                                       out_status: ST_BAD_HEX};
                    end else begin
                        n_phase = PH_PCT;
                    end
                end else begin
                    set.cnt    = 2'd1;
                    set.res[0] = '{out_byte: i_item.in_byte, out_last: i_item.in_last,
                                   out_status: ST_OK};
                end
            end
            PH_PCT: begin
                if (!is_hex(i_item.in_byte) || i_item.in_last) begin
                    set.cnt    = 2'd1;
                    set.res[0] = '{out_byte: 8'd0, out_last: 1'b1,
                                   out_status: ST_BAD_HEX};
                    n_phase    = i_item.in_last ? PH_IDLE : PH_DROP;
                end else begin
                    n_hi    = hex_val(i_item.in_byte);
                    n_phase = PH_HI;
                end
            end
            PH_HI: begin
                if (!is_hex(i_item.in_byte) || (oct == 8'd0)) begin
                    set.cnt    = 2'd1;
                    set.res[0] = '{out_byte: 8'd0, out_last: 1'b1,
                                   out_status: is_hex(i_item.in_byte) ? ST_NUL
                                                                      : ST_BAD_HEX};
                    n_phase    = i_item.in_last ? PH_IDLE : PH_DROP;
                end else begin
                    n_phase = PH_IDLE;
                    if (unreserved(oct)) begin
                        set.cnt    = 2'd1;
                        set.res[0] = '{out_byte: oct, out_last: i_item.in_last,
                                       out_status: ST_OK};
                    end else begin
                        // re-encode in canonical upper case
                        set.cnt    = 2'd3;
                        set.res[0] = '{out_byte: CH_PCT, out_last: 1'b0,
                                       out_status: ST_OK};
                        set.res[1] = '{out_byte: hex_char(oct[7:4]), out_last: 1'b0,
                                       out_status: ST_OK};
                        set.res[2] = '{out_byte: hex_char(oct[3:0]),
                                       out_last: i_item.in_last, out_status: ST_OK};
                    end
                end
            end
            PH_DROP: begin
                if (i_item.in_last) begin
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    assign o_set = set;

    // State registers advance only when a byte is consumed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_hi    <= 4'd0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_hi    <= n_hi;
        end
    end

    // An escape byte that is not the last of its string yields no output on its own
    a_pct_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && (r_phase == PH_IDLE) && (i_item.in_byte == CH_PCT) && !i_item.in_last
        |-> (o_set.cnt == 2'd0))
        else $error("escape start produced a result");

    // Any error moves to idle or drop
    a_err_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && (o_set.cnt == 2'd1) && (o_set.res[0].out_status != ST_OK)
        |=> (r_phase == PH_IDLE) || (r_phase == PH_DROP))
        else $error("error left escape state active");

    // Expansion only comes out of the second digit
    a_exp_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && (o_set.cnt == 2'd3) |-> (r_phase == PH_HI))
        else $error("three-beat expansion outside second digit");

endmodule

>>> hdl/upn_out_buf.sv
// ----------------------------------------------------------------------------
// upn_out_buf
// Result register: holds the up to three beats of one result set and
// presents them one per handshake.
// ----------------------------------------------------------------------------
module upn_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  upn_pkg::t_res_set i_set,
    output logic             o_can_load,
    output logic             o_valid,
    input  logic             i_ready,
    output upn_pkg::t_out    o_data
);
    import upn_pkg::*;

    t_out       r_res [MaxRes];
    logic [1:0] r_cnt;
    logic [1:0] r_idx;
    logic       pop;

    assign o_valid    = (r_cnt != 2'd0);
    assign pop        = o_valid && i_ready;
    assign o_can_load = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && pop);
    assign o_data     = r_res[r_idx];

    // Beat payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int k = 0; k < MaxRes; k++) begin
                r_res[k] <= i_set.res[k];
            end
        end
    end

    // Fill count and read pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_idx <= 2'd0;
        end else if (i_load) begin
            r_cnt <= i_set.cnt;
            r_idx <= 2'd0;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
            r_idx <= r_idx + 2'd1;
        end
    end

    // Never overwrite beats still pending
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (r_cnt == 2'd0) || ((r_cnt == 2'd1) && pop))
        else $error("result set loaded over pending beats");

    // Error beats carry zero byte and close the string
    a_err_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.out_status != ST_OK) |-> o_data.out_last && (o_data.out_byte == 8'd0))
        else $error("malformed error beat");

    // Only the final beat of a set may close the string
    a_last_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (r_cnt > 2'd1) |-> !o_data.out_last)
        else $error("last flag before end of expansion");

endmodule

>>> hdl/uri_percent_normalizer.sv
// ----------------------------------------------------------------------------
// uri_percent_normalizer
// Normalizes percent-escapes in a byte stream of URI strings.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes one byte per
//   beat, in_last on the final byte of a string. Output channel
//   (o_out_valid / i_out_ready / o_out_data) gives normalized bytes with a
//   status; an error beat has a zero byte and out_last set, and the rest of
//   that string is dropped.
//   A result beat passes the input register, then is decoded into the
//   result register. Throughput: one byte per cycle when each byte gives
//   at most one beat and the receiver is ready. A re-encoded escape gives
//   three beats and holds the decode stage until the last of them is taken
//   from the single-read result register.
//   Reset (i_rst_n low, synchronous) empties both registers and returns the
//   escape tracker to idle. If the receiver stalls, the result register
//   holds its beats and the input register still takes one more byte.
// ----------------------------------------------------------------------------
module uri_percent_normalizer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  upn_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output upn_pkg::t_out o_out_data
);
    import upn_pkg::*;

    logic     r_in_vld;
    t_in      r_in;
    logic     can_load;
    logic     dec_fire;
    t_res_set set;

    assign dec_fire   = r_in_vld && can_load;
    assign o_in_ready = !r_in_vld || dec_fire;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_vld <= 1'b1;
        end else if (dec_fire) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    // Escape decode
    upn_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (dec_fire),
        .i_item  (r_in),
        .o_set   (set)
    );

    // Result register
    upn_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (dec_fire),
        .i_set      (set),
        .o_can_load (can_load),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_data     (o_out_data)
    );

endmodule
